// ===== rtl/image_crc32_validator_top_assert.svh =====
// assertion macros shared by the validator modules
// each checks on the rising edge of clk and is off while arst_n is low
`ifndef IMAGE_CRC32_VALIDATOR_TOP_ASSERT_SVH
`define IMAGE_CRC32_VALIDATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property holds in the same cycle
`define CRCV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition implies a property in the next cycle
`define CRCV_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define CRCV_ASSERT(lbl, prop, msg)
`define CRCV_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// ===== rtl/crcv_pkg.sv =====
package crcv_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SIZE = 2'd2;

	// input item kinds
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA = 1'b1;

	// crc constants
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
	localparam logic [31:0] CRC_ZERO = 32'h00000000;

	// default depth of the command queue
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		ST_OK,
		ST_NO_MAGIC,
		ST_BAD_CRC,
		ST_BAD_LEN,
		ST_MISMATCH
	} status_t;

	typedef enum logic [1:0] {
		CMD_ERR,
		CMD_START,
		CMD_WORD,
		CMD_LAST
	} cmd_kind_t;

	// one command from the front to the back
	typedef struct packed {
		cmd_kind_t   kind;
		status_t     status;
		logic [31:0] data;
	} cmd_t;

	// command with its valid flag
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_xfer_t;

	typedef logic [31:0][31:0] crc_mat_t;

	// contribution of each input bit after 32 reflected bit steps
	function automatic crc_mat_t crc_columns();
		crc_mat_t m;
		logic [31:0] c;
		for (int i = 0; i < 32; i++) begin
			c = 32'h1 << i;
			for (int j = 0; j < 32; j++) begin
				c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
			end
			m[i] = c;
		end
		return m;
	endfunction

	localparam crc_mat_t CRC_MAT = crc_columns();

	// one word update as a flat xor network
	function automatic logic [31:0] crc_word(logic [31:0] crc, logic [31:0] word);
		logic [31:0] x;
		logic [31:0] r;
		x = crc ^ word;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (x[i]) begin
				r = r ^ CRC_MAT[i];
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/crcv_front.sv =====
`include "image_crc32_validator_top_assert.svh"

module crcv_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [crcv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// header_magic, stored_crc, image_size, data_word
	input  logic [127:0]                     s_tdata,
	// op
	input  logic                             s_tuser,
	input  logic                             q_full,
	output crcv_pkg::cmd_xfer_t              push
);
	import crcv_pkg::*;

	logic [31:0] magic_q;
	logic [31:0] max_size_q;
	logic [31:0] min_size_q;
	logic        armed_q;
	logic [29:0] words_left_q;
	logic        armed_d;
	logic [29:0] words_left_d;

	logic [31:0] hdr_magic;
	logic [31:0] hdr_crc;
	logic [31:0] hdr_size;
	logic [31:0] dat_word;
	logic [31:0] size_m4;
	logic [29:0] start_cnt;
	logic        accept;

	assign hdr_magic = s_tdata[31:0];
	assign hdr_crc   = s_tdata[63:32];
	assign hdr_size  = s_tdata[95:64];
	assign dat_word  = s_tdata[127:96];
	assign size_m4   = hdr_size - 32'd4;
	assign start_cnt = size_m4[31:2];

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q    <= 32'h0;
			max_size_q <= 32'hFFFFFFFF;
			min_size_q <= 32'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAGIC:    magic_q    <= cfg_data;
				REG_MAX_SIZE: max_size_q <= cfg_data;
				REG_MIN_SIZE: min_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// classify the transfer and track the word count
	always_comb begin
		push.valid      = 1'b0;
		push.cmd.kind   = CMD_ERR;
		push.cmd.status = ST_OK;
		push.cmd.data   = CRC_ZERO;
		armed_d         = armed_q;
		words_left_d    = words_left_q;
		if (accept) begin
			if (s_tuser == OP_HEADER) begin
				armed_d      = 1'b0;
				words_left_d = '0;
				push.valid   = 1'b1;
				if (hdr_magic != magic_q) begin
					push.cmd.status = ST_NO_MAGIC;
				end else if (hdr_crc == CRC_INIT || hdr_crc == CRC_ZERO) begin
					push.cmd.status = ST_BAD_CRC;
				end else if (hdr_size >= max_size_q || hdr_size < min_size_q) begin
					push.cmd.status = ST_BAD_LEN;
				end else if (start_cnt == '0) begin
					// empty image: inverted init crc is zero, never a valid stored crc
					push.cmd.status = ST_MISMATCH;
				end else begin
					push.cmd.kind = CMD_START;
					push.cmd.data = hdr_crc;
					armed_d       = 1'b1;
					words_left_d  = start_cnt;
				end
			end else if (armed_q) begin
				push.valid    = 1'b1;
				push.cmd.data = dat_word;
				if (words_left_q == 30'd1) begin
					push.cmd.kind = CMD_LAST;
					armed_d       = 1'b0;
					words_left_d  = '0;
				end else begin
					push.cmd.kind = CMD_WORD;
					words_left_d  = words_left_q - 30'd1;
				end
			end
		end
	end

	// validation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			words_left_q <= '0;
		end else begin
			armed_q      <= armed_d;
			words_left_q <= words_left_d;
		end
	end

	`CRCV_ASSERT(a_armed_count, (!armed_q || words_left_q != '0), "armed with no words left")

endmodule

// ===== rtl/crcv_queue.sv =====
`include "image_crc32_validator_top_assert.svh"

module crcv_queue #(
	parameter int DEPTH = crcv_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  crcv_pkg::cmd_xfer_t push,
	input  logic                pop,
	output logic                full,
	output crcv_pkg::cmd_xfer_t head
);
	import crcv_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_FULL);
	assign head.valid = (count_q != '0);
	assign head.cmd   = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CRCV_ASSERT(a_no_push_full, (!push.valid || !full), "push into full queue")
	`CRCV_ASSERT(a_no_pop_empty, (!pop || head.valid), "pop from empty queue")
	`CRCV_ASSERT_NEXT(a_count_up, (push.valid && !pop), (count_q == $past(count_q) + 1'b1), "count did not rise")

endmodule

// ===== rtl/crcv_back.sv =====
`include "image_crc32_validator_top_assert.svh"

module crcv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  crcv_pkg::cmd_xfer_t head,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	// status [2:0], computed_crc [34:3], zero fill [39:35]
	output logic [39:0]         m_tdata
);
	import crcv_pkg::*;

	logic [31:0] crc_q;
	logic [31:0] exp_q;
	logic        out_valid_q;
	status_t     out_status_q;
	logic [31:0] out_crc_q;

	logic [31:0] crc_next;
	logic [31:0] crc_final;
	logic        emits;

	assign crc_next  = crc_word(crc_q, head.cmd.data);
	assign crc_final = ~crc_next;
	assign emits     = (head.cmd.kind == CMD_ERR) || (head.cmd.kind == CMD_LAST);
	assign pop       = head.valid && (!emits || !out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_crc_q, out_status_q};

	// running crc and expected value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			exp_q <= CRC_ZERO;
		end else if (pop) begin
			unique case (head.cmd.kind)
				CMD_START: begin
					crc_q <= CRC_INIT;
					exp_q <= head.cmd.data;
				end
				CMD_WORD:  crc_q <= crc_next;
				CMD_LAST:  crc_q <= crc_next;
				CMD_ERR:   ;
				default:   ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emits) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && emits) begin
			if (head.cmd.kind == CMD_LAST) begin
				out_crc_q    <= crc_final;
				out_status_q <= (crc_final == exp_q) ? ST_OK : ST_MISMATCH;
			end else begin
				out_crc_q    <= head.cmd.data;
				out_status_q <= head.cmd.status;
			end
		end
	end

	`CRCV_ASSERT_NEXT(a_result_shown, (pop && emits), m_tvalid, "result not registered")
	`CRCV_ASSERT(a_stall_reason, (!head.valid || pop || (m_tvalid && !m_tready)), "queue stalled for no reason")

endmodule

// ===== rtl/image_crc32_validator_top.sv =====
// a result is stored in a command queue entry and then in the output register before tvalid rises
// throughput: one item per cycle unless the queue is full or the output stalls, set by the
// combinational 32-bit xor network of the crc unit
// a command queue of QUEUE_DEPTH entries decouples input transfers from output stalls
// reset: arst_n clears all control state and loads register defaults at once
// no clearing pass is needed after reset
module image_crc32_validator_top #(
	parameter int QUEUE_DEPTH = crcv_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [crcv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// header_magic [31:0], stored_crc [63:32], image_size [95:64], data_word [127:96]
	input  logic [127:0]                   s_tdata,
	// op
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// status [2:0], computed_crc [34:3], zero fill [39:35]
	output logic [39:0]                    m_tdata
);
	import crcv_pkg::*;

	cmd_xfer_t push;
	cmd_xfer_t head;
	logic      q_full;
	logic      pop;

	// header checks and word counting
	crcv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push)
	);

	// command queue
	crcv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	// crc update and result output
	crcv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
